// File: hdl/gfcp_pkg.sv
package gfcp_pkg;

	// fixed field widths of the command and response beats
	localparam int CMD_W   = 2;
	localparam int X_W     = 5;
	localparam int Y_W     = 7;
	localparam int RND_W   = 16;
	localparam int STAT_W  = 3;
	localparam int FCNT_W  = 12;
	localparam int CFG_W   = 7;
	localparam int NUM_W   = 13;
	localparam int STEP_W  = $clog2(RND_W);

	// register reset values
	localparam logic [X_W-1:0] WIDTH_RST  = 5'd24;
	localparam logic [Y_W-1:0] HEIGHT_RST = 7'd79;

	// register indexes
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_INIT   = 2'd0,
		CMD_OCCUPY = 2'd1,
		CMD_FREE   = 2'd2,
		CMD_PICK   = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_DONE     = 3'd0,
		STAT_WALL     = 3'd1,
		STAT_OCCUPIED = 3'd2,
		STAT_FREE     = 3'd3,
		STAT_EMPTY    = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CALC,
		ST_FILL,
		ST_MAP_RD,
		ST_POOL_RD,
		ST_CHECK,
		ST_LAST_RD,
		ST_MOD_WAIT,
		ST_SLOT_RD,
		ST_XY_WAIT,
		ST_DONE
	} state_t;

endpackage

// File: hdl/gfcp_ram.sv
module gfcp_ram #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 11
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/gfcp_div.sv
module gfcp_div import gfcp_pkg::*; #(
	parameter int DVW = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [RND_W-1:0] dividend,
	input  logic [DVW-1:0]   divisor,
	output logic             done,
	output logic [RND_W-1:0] quotient,
	output logic [DVW-1:0]   remainder
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [RND_W-1:0]  quo_q;
	logic [DVW-1:0]    rem_q;
	logic [DVW-1:0]    den_q;
	logic [DVW:0]      trial;
	logic [DVW:0]      diff;
	logic              ge;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_q, quo_q[RND_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(RND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[RND_W-2:0], ge};
			rem_q <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// File: hdl/grid_free_cell_pool_unit.sv
// free-cell pool of a walled grid, kept as a sparse set
// command channel: cmd_valid / cmd_stall carry one beat of command, x_coord,
// y_coord and random_value; a beat is taken when cmd_valid is high and
// cmd_stall is low. cmd_stall is high while a command is being worked on.
// response channel: rsp_valid / rsp_stall carry one beat per command with
// status, cell_x, cell_y and free_count. the response sits in an output
// register, so a stalled response does not keep the next command out.
// config: cfg_we writes cfg_data into interior_width (index 0) or
// interior_height (index 1); the new geometry is used at the next init.
// states, command taken to response valid (wall, empty pick: calc, done):
//   init   calc, fill (one pool and map entry written per cycle), done
//   occupy/free calc, map rd, pool rd, check, last rd if removing, done
//   pick   two 16-step divides on the shared divider, then the occupy walk
// one command in flight at a time; the next one is taken in the cycle after
// the response is loaded, so a command starts only once the last has finished.
// reset clears the pool count to zero and loads the register reset values;
// the pool and map memories are not cleared and need no clearing pass.
// a stalled response holds; the block finishes the next command but waits
// in its last state until the output register is free again.
module grid_free_cell_pool_unit import gfcp_pkg::*; #(
	parameter int MAX_CELLS = 2048
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  logic [CMD_W-1:0]  command,
	input  logic [X_W-1:0]    x_coord,
	input  logic [Y_W-1:0]    y_coord,
	input  logic [RND_W-1:0]  random_value,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [STAT_W-1:0] status,
	output logic [X_W-1:0]    cell_x,
	output logic [Y_W-1:0]    cell_y,
	output logic [FCNT_W-1:0] free_count
);

	localparam int CW   = $clog2(MAX_CELLS);
	localparam int CNTW = $clog2(MAX_CELLS + 1);

	state_t state_q, state_d;

	// registers and latched geometry
	logic [X_W-1:0]   width_q;
	logic [Y_W-1:0]   height_q;
	logic [X_W-1:0]   geo_w_q;
	logic [Y_W-1:0]   geo_h_q;
	logic [CNTW-1:0]  count_q;

	// command being worked on
	cmd_t             cmd_q;
	logic [X_W-1:0]   x_q;
	logic [Y_W-1:0]   y_q;
	logic [RND_W-1:0] rnd_q;
	logic [CW-1:0]    cell_q;
	logic [CW-1:0]    slot_q;
	logic [CNTW-1:0]  fill_idx_q;
	status_t          stat_q;
	logic [X_W-1:0]   ox_q;
	logic [Y_W-1:0]   oy_q;

	// response register
	logic              rsp_valid_q;
	logic [STAT_W-1:0] rsp_status_q;
	logic [X_W-1:0]    rsp_x_q;
	logic [Y_W-1:0]    rsp_y_q;
	logic [FCNT_W-1:0] rsp_count_q;

	// memory ports
	logic          pool_we, map_we;
	logic [CW-1:0] pool_waddr, pool_wdata, pool_raddr, pool_rdata;
	logic [CW-1:0] map_waddr, map_wdata, map_raddr, map_rdata;

	// shared divider
	logic             div_start, div_done;
	logic [RND_W-1:0] div_dividend, div_quo;
	logic [CNTW-1:0]  div_divisor, div_rem;

	logic             cmd_accept, rsp_free;
	logic [Y_W-1:0]   mult_a;
	logic [FCNT_W-1:0] prod;
	logic [NUM_W-1:0] cell_sum;
	logic             in_range;
	logic [CNTW-1:0]  total_clamp;
	logic [CNTW-1:0]  last_idx;
	logic             is_free;
	logic             append_en;

	assign cmd_accept = cmd_valid && !cmd_stall;
	assign rsp_free   = !rsp_valid_q || !rsp_stall;

	// one small multiplier: rows times width for init, cell number otherwise
	always_comb begin
		mult_a   = (cmd_q == CMD_INIT) ? geo_h_q : (y_q - Y_W'(1));
		prod     = FCNT_W'(mult_a) * FCNT_W'(geo_w_q);
		cell_sum = NUM_W'(prod) + NUM_W'(x_q - X_W'(1));
		in_range = (x_q != '0) && (x_q <= geo_w_q) && (y_q != '0) && (y_q <= geo_h_q)
			&& (32'(cell_sum) < MAX_CELLS);
		total_clamp = (32'(prod) > MAX_CELLS) ? CNTW'(MAX_CELLS) : CNTW'(prod);
		last_idx    = count_q - CNTW'(1);
		// membership: the slot is live and points back at the cell
		is_free     = (CNTW'(slot_q) < count_q) && (pool_rdata == cell_q);
	end

	gfcp_ram #(
		.DEPTH (MAX_CELLS),
		.WIDTH (CW)
	) u_pool (
		.clk   (clk),
		.we    (pool_we),
		.waddr (pool_waddr),
		.wdata (pool_wdata),
		.raddr (pool_raddr),
		.rdata (pool_rdata)
	);

	gfcp_ram #(
		.DEPTH (MAX_CELLS),
		.WIDTH (CW)
	) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	gfcp_div #(
		.DVW (CNTW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_accept) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				case (cmd_q)
					CMD_INIT:   state_d = (total_clamp == '0) ? ST_DONE : ST_FILL;
					CMD_OCCUPY: state_d = in_range ? ST_MAP_RD : ST_DONE;
					CMD_FREE:   state_d = in_range ? ST_MAP_RD : ST_DONE;
					CMD_PICK:   state_d = (count_q == '0) ? ST_DONE : ST_MOD_WAIT;
					default:    state_d = ST_DONE;
				endcase
			end
			ST_FILL: begin
				if (fill_idx_q == last_idx) begin
					state_d = ST_DONE;
				end
			end
			ST_MAP_RD:  state_d = ST_POOL_RD;
			ST_POOL_RD: state_d = ST_CHECK;
			ST_CHECK: begin
				if (cmd_q == CMD_FREE || !is_free) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_LAST_RD;
				end
			end
			ST_LAST_RD: state_d = ST_DONE;
			ST_MOD_WAIT: begin
				if (div_done) begin
					state_d = ST_SLOT_RD;
				end
			end
			ST_SLOT_RD: state_d = (geo_w_q != '0) ? ST_XY_WAIT : ST_MAP_RD;
			ST_XY_WAIT: begin
				if (div_done) begin
					state_d = ST_MAP_RD;
				end
			end
			ST_DONE: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory, divider and handshake controls
	always_comb begin
		cmd_stall    = (state_q != ST_IDLE);
		pool_we      = 1'b0;
		pool_waddr   = '0;
		pool_wdata   = '0;
		pool_raddr   = '0;
		map_we       = 1'b0;
		map_waddr    = '0;
		map_wdata    = '0;
		map_raddr    = '0;
		div_start    = 1'b0;
		div_dividend = rnd_q;
		div_divisor  = count_q;
		append_en    = 1'b0;
		case (state_q)
			ST_CALC: begin
				if (cmd_q == CMD_PICK && count_q != '0) begin
					div_start = 1'b1;
				end
			end
			ST_FILL: begin
				pool_we    = 1'b1;
				pool_waddr = fill_idx_q[CW-1:0];
				pool_wdata = fill_idx_q[CW-1:0];
				map_we     = 1'b1;
				map_waddr  = fill_idx_q[CW-1:0];
				map_wdata  = fill_idx_q[CW-1:0];
			end
			ST_MAP_RD: begin
				map_raddr = cell_q;
			end
			ST_POOL_RD: begin
				pool_raddr = map_rdata;
			end
			ST_CHECK: begin
				// fetch the last entry for a removal
				pool_raddr = last_idx[CW-1:0];
				// free of an occupied cell appends it while there is room
				if (cmd_q == CMD_FREE && !is_free && count_q < CNTW'(MAX_CELLS)) begin
					append_en  = 1'b1;
					pool_we    = 1'b1;
					pool_waddr = count_q[CW-1:0];
					pool_wdata = cell_q;
					map_we     = 1'b1;
					map_waddr  = cell_q;
					map_wdata  = count_q[CW-1:0];
				end
			end
			ST_LAST_RD: begin
				// last entry moves into the freed slot
				pool_we    = 1'b1;
				pool_waddr = slot_q;
				pool_wdata = pool_rdata;
				map_we     = 1'b1;
				map_waddr  = pool_rdata;
				map_wdata  = slot_q;
			end
			ST_MOD_WAIT: begin
				pool_raddr = div_rem[CW-1:0];
			end
			ST_SLOT_RD: begin
				div_dividend = RND_W'(pool_rdata);
				div_divisor  = CNTW'(geo_w_q);
				if (geo_w_q != '0) begin
					div_start = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			width_q     <= WIDTH_RST;
			height_q    <= HEIGHT_RST;
			geo_w_q     <= WIDTH_RST;
			geo_h_q     <= HEIGHT_RST;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_WIDTH:  width_q  <= cfg_data[X_W-1:0];
					REG_HEIGHT: height_q <= cfg_data[Y_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd_accept && cmd_t'(command) == CMD_INIT) begin
				geo_w_q <= width_q;
				geo_h_q <= height_q;
			end
			if (state_q == ST_CALC && cmd_q == CMD_INIT) begin
				count_q <= total_clamp;
			end else if (append_en) begin
				count_q <= count_q + CNTW'(1);
			end else if (state_q == ST_LAST_RD) begin
				count_q <= last_idx;
			end
			if (state_q == ST_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// command and response payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_accept) begin
					cmd_q      <= cmd_t'(command);
					x_q        <= x_coord;
					y_q        <= y_coord;
					rnd_q      <= random_value;
					stat_q     <= STAT_DONE;
					ox_q       <= '0;
					oy_q       <= '0;
					fill_idx_q <= '0;
				end
			end
			ST_CALC: begin
				cell_q <= cell_sum[CW-1:0];
				if ((cmd_q == CMD_OCCUPY || cmd_q == CMD_FREE) && !in_range) begin
					stat_q <= STAT_WALL;
				end
				if (cmd_q == CMD_PICK && count_q == '0) begin
					stat_q <= STAT_EMPTY;
				end
			end
			ST_FILL: begin
				fill_idx_q <= fill_idx_q + CNTW'(1);
			end
			ST_POOL_RD: begin
				slot_q <= map_rdata;
			end
			ST_CHECK: begin
				if (cmd_q == CMD_OCCUPY && !is_free) begin
					stat_q <= STAT_OCCUPIED;
				end
				if (cmd_q == CMD_FREE && is_free) begin
					stat_q <= STAT_FREE;
				end
			end
			ST_SLOT_RD: begin
				cell_q <= pool_rdata;
			end
			ST_XY_WAIT: begin
				if (div_done) begin
					ox_q <= X_W'(div_rem) + X_W'(1);
					oy_q <= Y_W'(div_quo) + Y_W'(1);
				end
			end
			ST_DONE: begin
				if (rsp_free) begin
					rsp_status_q <= stat_q;
					rsp_x_q      <= ox_q;
					rsp_y_q      <= oy_q;
					rsp_count_q  <= FCNT_W'(count_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid  = rsp_valid_q;
	assign status     = rsp_status_q;
	assign cell_x     = rsp_x_q;
	assign cell_y     = rsp_y_q;
	assign free_count = rsp_count_q;

endmodule
